FILE: sv/phce_pkg.sv
// Shared types and constants for the piecewise heat capacity evaluator.
`timescale 1ns / 1ps
package phce_pkg;

  // Input item kind codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // ln(2) in Q4.30, operand width of the shared multiplier
  localparam logic signed [33:0] LN2_Q30 = 34'sd744261118;
  localparam int unsigned LOG_FRAC_BITS = 24;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic                kind;
    logic [3:0]          entry_index;
    logic [31:0]         temperature;
    logic signed [31:0]  entry_cp;
    logic signed [47:0]  entry_enthalpy;
    logic signed [31:0]  entry_entropy;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] cp_r;
    logic signed [31:0] h_rt;
    logic signed [31:0] s_r;
    logic [1:0]         status;
  } out_item_t;

  // Command classes produced by the front end
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_DROP,
    CMD_EVAL,
    CMD_EVAL_ZERO
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e op;
    in_item_t  item;
  } cmd_t;

endpackage

FILE: sv/phce_fifo.sv
// Small synchronous FIFO used as the command queue and the result queue.
`timescale 1ns / 1ps
module phce_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             wr_ok, rd_ok;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_ok   = wr_i && !full_o;
  assign rd_ok   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_ok && !rd_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_ok && !wr_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: sv/phce_front.sv
// Front end: accepts input transactions and classifies them into commands.
`timescale 1ns / 1ps
module phce_front #(
  parameter int MaxPoints = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  phce_pkg::in_item_t item_i,
  output logic               full_o,
  output logic               cmd_valid_o,
  output phce_pkg::cmd_t     cmd_o,
  input  logic               cmd_ready_i
);
  import phce_pkg::*;

  logic valid_q;
  cmd_t cmd_q, cmd_d;
  logic accept;

  assign full_o      = valid_q && !cmd_ready_i;
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  // Classify: loads outside the table are dropped, zero queries short-cut
  always_comb begin
    cmd_d.item = item_i;
    unique case (item_i.kind)
      KIND_LOAD: begin
        cmd_d.op = (32'(item_i.entry_index) < 32'(MaxPoints)) ? CMD_LOAD : CMD_DROP;
      end
      KIND_EVAL: begin
        cmd_d.op = (item_i.temperature == '0) ? CMD_EVAL_ZERO : CMD_EVAL;
      end
      default: begin
        cmd_d.op = CMD_DROP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (cmd_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

FILE: sv/phce_back.sv
// Back end: breakpoint table, interval search and the fixed-point sequencer.
`timescale 1ns / 1ps
module phce_back #(
  parameter int MaxPoints = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  phce_pkg::cmd_t      cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  output phce_pkg::out_item_t res_o,
  output logic                res_push_o,
  input  logic                res_full_i
);
  import phce_pkg::*;

  localparam int IW  = $clog2(MaxPoints);
  localparam int DvW = 67;  // 51-bit magnitude plus 16 fraction bits

  localparam logic [3:0] B_IDLE   = 4'd0;
  localparam logic [3:0] B_SCAN   = 4'd1;
  localparam logic [3:0] B_FETCH  = 4'd2;
  localparam logic [3:0] B_HMUL   = 4'd3;
  localparam logic [3:0] B_HSUM   = 4'd4;
  localparam logic [3:0] B_DIV    = 4'd5;
  localparam logic [3:0] B_HSAT   = 4'd6;
  localparam logic [3:0] B_NORM   = 4'd7;
  localparam logic [3:0] B_SQM    = 4'd8;
  localparam logic [3:0] B_SQA    = 4'd9;
  localparam logic [3:0] B_LOGEND = 4'd10;
  localparam logic [3:0] B_LNMUL  = 4'd11;
  localparam logic [3:0] B_SMUL   = 4'd12;
  localparam logic [3:0] B_SSUM   = 4'd13;
  localparam logic [3:0] B_OUT    = 4'd14;

  // Breakpoint table
  logic [31:0]        tab_t  [MaxPoints];
  logic signed [31:0] tab_cp [MaxPoints];
  logic signed [47:0] tab_h  [MaxPoints];
  logic signed [31:0] tab_s  [MaxPoints];

  logic [3:0]         state_q;
  logic [4:0]         npts_q;
  logic [IW-1:0]      scan_q, rd_idx, nint;
  logic [6:0]         npts_c;
  logic               zero_q, lg_sel_q, sat_q, hneg_q;
  logic [31:0]        t_q, t1_q, m_q;
  logic signed [31:0] cp_q, si_q;
  logic signed [47:0] hi_q;
  logic signed [67:0] prod_q, prod_d;
  logic signed [33:0] mul_a, mul_b;
  logic [DvW-1:0]     dq_q;
  logic [31:0]        rem_q;
  logic [6:0]         cnt_q;
  logic [4:0]         msb_q;
  logic [23:0]        frac_q;
  logic signed [30:0] lt_q;
  out_item_t          res_q;

  // Datapath helpers
  logic signed [50:0] hn;
  logic [50:0]        habs;
  logic [32:0]        rem_sh, rem_n;
  logic               div_ge;
  logic [32:0]        msq;
  logic signed [29:0] lg;
  logic signed [44:0] sv;

  assign cmd_pop_o  = (state_q == B_IDLE) && !cmd_empty_i;
  assign res_push_o = (state_q == B_OUT) && !res_full_i;
  assign res_o      = res_q;

  // Clamp the point count to between 2 and the table size
  always_comb begin
    if (npts_q < 5'd2) begin
      npts_c = 7'd2;
    end else if (7'(npts_q) > 7'(MaxPoints)) begin
      npts_c = 7'(MaxPoints);
    end else begin
      npts_c = 7'(npts_q);
    end
    nint = IW'(npts_c - 7'd1);
  end

  assign rd_idx = (state_q == B_SCAN) ? scan_q + 1'b1 : scan_q;

  // Shared multiplier operand select
  always_comb begin
    unique case (state_q)
      B_HMUL: begin
        mul_a = $signed({2'b00, t_q}) - $signed({2'b00, t1_q});
        mul_b = 34'(cp_q);
      end
      B_SQM: begin
        mul_a = $signed({2'b00, m_q});
        mul_b = $signed({2'b00, m_q});
      end
      B_LNMUL: begin
        mul_a = 34'(lt_q);
        mul_b = LN2_Q30;
      end
      B_SMUL: begin
        mul_a = 34'($signed(prod_q[59:30]));
        mul_b = 34'(cp_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_d = mul_a * mul_b;

  // Arithmetic between the sequencer steps
  assign hn     = 51'(hi_q) + 51'($signed(prod_q[66:16]));
  assign habs   = hn[50] ? 51'(-hn) : 51'(hn);
  assign rem_sh = {rem_q, dq_q[DvW-1]};
  assign div_ge = rem_sh >= {1'b0, t_q};
  assign rem_n  = div_ge ? rem_sh - {1'b0, t_q} : rem_sh;
  assign msq    = prod_q[63:31];
  assign lg     = {6'({1'b0, msb_q}) - 6'd16, frac_q};
  assign sv     = 45'(si_q) + 45'($signed(prod_q[67:24]));

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      npts_q   <= 5'd2;
      scan_q   <= '0;
      cnt_q    <= '0;
      zero_q   <= 1'b0;
      lg_sel_q <= 1'b0;
      sat_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        npts_q <= cfg_wdata_i;
      end
      unique case (state_q)
        B_IDLE: begin
          if (!cmd_empty_i) begin
            zero_q <= (cmd_i.op == CMD_EVAL_ZERO);
            sat_q  <= 1'b0;
            scan_q <= '0;
            if ((cmd_i.op == CMD_EVAL) || (cmd_i.op == CMD_EVAL_ZERO)) begin
              state_q <= B_SCAN;
            end else begin
              state_q <= B_OUT;
            end
          end
        end
        B_SCAN: begin
          if (scan_q == nint) begin
            state_q <= B_FETCH;
          end else if (t_q <= tab_t[rd_idx]) begin
            state_q <= B_FETCH;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        B_FETCH: begin
          state_q <= zero_q ? B_OUT : B_HMUL;
        end
        B_HMUL: begin
          state_q <= B_HSUM;
        end
        B_HSUM: begin
          cnt_q   <= '0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 7'(DvW - 1)) begin
            state_q <= B_HSAT;
          end
        end
        B_HSAT: begin
          if (dq_q > (hneg_q ? 67'h80000000 : 67'h7fffffff)) begin
            sat_q <= 1'b1;
          end
          lg_sel_q <= 1'b0;
          state_q  <= (t1_q == '0) ? B_SSUM : B_NORM;
        end
        B_NORM: begin
          if (m_q[31]) begin
            cnt_q   <= '0;
            state_q <= B_SQM;
          end
        end
        B_SQM: begin
          state_q <= B_SQA;
        end
        B_SQA: begin
          cnt_q <= cnt_q + 1'b1;
          state_q <= (cnt_q == 7'(LOG_FRAC_BITS - 1)) ? B_LOGEND : B_SQM;
        end
        B_LOGEND: begin
          lg_sel_q <= 1'b1;
          state_q  <= lg_sel_q ? B_LNMUL : B_NORM;
        end
        B_LNMUL: begin
          state_q <= B_SMUL;
        end
        B_SMUL: begin
          state_q <= B_SSUM;
        end
        B_SSUM: begin
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (!res_full_i) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        t_q   <= cmd_i.item.temperature;
        res_q <= '0;
      end
      B_FETCH: begin
        t1_q       <= tab_t[rd_idx];
        cp_q       <= tab_cp[rd_idx];
        hi_q       <= tab_h[rd_idx];
        si_q       <= tab_s[rd_idx];
        res_q.cp_r <= tab_cp[rd_idx];
        if (zero_q) begin
          res_q.status <= ST_ZERO;
        end
      end
      B_HMUL: begin
        prod_q <= prod_d;
      end
      B_HSUM: begin
        hneg_q <= hn[50];
        dq_q   <= {habs, 16'h0000};
        rem_q  <= '0;
      end
      B_DIV: begin
        rem_q <= rem_n[31:0];
        dq_q  <= {dq_q[DvW-2:0], div_ge};
      end
      B_HSAT: begin
        if (hneg_q) begin
          res_q.h_rt <= (dq_q > 67'h80000000) ? S32_MIN : 32'(-dq_q[31:0]);
        end else begin
          res_q.h_rt <= (dq_q > 67'h7fffffff) ? S32_MAX : $signed(dq_q[31:0]);
        end
        m_q   <= t_q;
        msb_q <= 5'd31;
      end
      B_NORM: begin
        frac_q <= '0;
        if (!m_q[31]) begin
          m_q   <= {m_q[30:0], 1'b0};
          msb_q <= msb_q - 1'b1;
        end
      end
      B_SQM: begin
        prod_q <= prod_d;
      end
      B_SQA: begin
        frac_q <= {frac_q[22:0], msq[32]};
        m_q    <= msq[32] ? msq[32:1] : msq[31:0];
      end
      B_LOGEND: begin
        // First pass leaves log2(T), second subtracts log2(T_i)
        if (lg_sel_q) begin
          lt_q <= lt_q - 31'(lg);
        end else begin
          lt_q  <= 31'(lg);
          m_q   <= t1_q;
          msb_q <= 5'd31;
        end
      end
      B_LNMUL, B_SMUL: begin
        prod_q <= prod_d;
      end
      B_SSUM: begin
        if (t1_q == '0) begin
          // Breakpoint at zero: log is unbounded
          if (cp_q > 0) begin
            res_q.s_r <= S32_MAX;
          end else if (cp_q < 0) begin
            res_q.s_r <= S32_MIN;
          end else begin
            res_q.s_r <= si_q;
          end
          res_q.status <= (sat_q || (cp_q != 0)) ? ST_SAT : ST_OK;
        end else if (sv > 45'sd2147483647) begin
          res_q.s_r    <= S32_MAX;
          res_q.status <= ST_SAT;
        end else if (sv < -45'sd2147483648) begin
          res_q.s_r    <= S32_MIN;
          res_q.status <= ST_SAT;
        end else begin
          res_q.s_r    <= sv[31:0];
          res_q.status <= sat_q ? ST_SAT : ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Table write on load commands
  always_ff @(posedge clk_i) begin
    if ((state_q == B_IDLE) && !cmd_empty_i && (cmd_i.op == CMD_LOAD)) begin
      tab_t[IW'(cmd_i.item.entry_index)]  <= cmd_i.item.temperature;
      tab_cp[IW'(cmd_i.item.entry_index)] <= cmd_i.item.entry_cp;
      tab_h[IW'(cmd_i.item.entry_index)]  <= cmd_i.item.entry_enthalpy;
      tab_s[IW'(cmd_i.item.entry_index)]  <= cmd_i.item.entry_entropy;
    end
  end

  // Checks
  a_push_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> state_q == B_OUT)
    else $error("result pushed outside output step");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_SCAN |-> scan_q <= nint)
    else $error("interval search ran past last interval");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> cnt_q < 7'(DvW))
    else $error("divider ran too many steps");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && (res_q.status == ST_ZERO)) |-> (res_q.h_rt == 0) && (res_q.s_r == 0))
    else $error("zero-temperature result carries nonzero properties");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> state_q != B_IDLE)
    else $error("command popped but sequencer stayed idle");

endmodule

FILE: sv/piecewise_heat_capacity_eval.sv
// Top level: front end, command queue, evaluation back end and result queue.
// Sequence: each load also reaches the result port; an evaluation runs S search steps (up to
//   number_of_points - 1), the serial divide and the normalize shifts N1 and N2 (up to 31 each)
//   for log2 of T and T_i; a zero query ends after the search and table fetch.
// Throughput: one item at a time in the back end, set by the serial divider and log2 loops.
// Reset: rst_ni async active low; queues empty, number_of_points = 2, table undefined.
`timescale 1ns / 1ps
module piecewise_heat_capacity_eval #(
  parameter int MaxPoints = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic                push_i,
  input  phce_pkg::in_item_t  item_i,
  output logic                full_o,
  output logic                empty_o,
  input  logic                pop_i,
  output phce_pkg::out_item_t result_o
);
  import phce_pkg::*;

  logic      cmd_valid, cmd_full, cmd_empty, cmd_pop;
  cmd_t      cmd_front, cmd_back;
  out_item_t res_back;
  logic      res_push, res_full;

  phce_front #(.MaxPoints(MaxPoints)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .item_i      (item_i),
    .full_o      (full_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_front),
    .cmd_ready_i (!cmd_full)
  );

  phce_fifo #(.Width($bits(cmd_t)), .Depth(2)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_valid),
    .wdata_i (cmd_front),
    .full_o  (cmd_full),
    .rd_i    (cmd_pop),
    .rdata_o (cmd_back),
    .empty_o (cmd_empty)
  );

  phce_back #(.MaxPoints(MaxPoints)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_back),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_back),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  phce_fifo #(.Width($bits(out_item_t)), .Depth(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (res_back),
    .full_o  (res_full),
    .rd_i    (pop_i),
    .rdata_o (result_o),
    .empty_o (empty_o)
  );

endmodule
